// ===== rtl/obrs_pkg.sv =====
package obrs_pkg;

	// Frame length and field widths.
	localparam int BLOCK_LEN = 220;
	localparam int WORD_W    = 16;
	localparam int SAMPLE_W  = 12;
	localparam int POS_W     = $clog2(BLOCK_LEN);
	localparam int SUM_W     = SAMPLE_W + POS_W;

	// Reset value of the outlier threshold.
	localparam logic [SAMPLE_W-1:0] THRESH_RESET = SAMPLE_W'(400);

	// Last position of a frame.
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_LEN - 1);

	// Reciprocal for floor(sum / BLOCK_LEN): with a shift of SUM_W + POS_W and a
	// rounded-up multiplier the quotient is exact for every sum below 2**SUM_W.
	localparam int RECIP_SHIFT = SUM_W + POS_W;
	localparam int RECIP_W     = SUM_W + 1;
	localparam int PROD_W      = SUM_W + RECIP_W;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << RECIP_SHIFT) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN);
	localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_FULL[RECIP_W-1:0];

	// Frame status from the mean unit to the rest of the block.
	typedef struct packed {
		logic             held;      // a complete frame is stored
		logic             held_par;  // bank of the mean of the stored frame
		logic [POS_W-1:0] pos;       // position in the frame being loaded
	} frame_stat_t;

	// One stored sample on its way to the output stage.
	typedef struct packed {
		logic [SAMPLE_W-1:0] held;
		logic                par;
		logic                last;
	} held_item_t;

endpackage

// ===== rtl/obrs_cell.sv =====
module obrs_cell (
	input  logic                          clk,
	input  logic                          en,
	input  logic [obrs_pkg::SAMPLE_W-1:0] d,
	output logic [obrs_pkg::SAMPLE_W-1:0] q
);
	import obrs_pkg::*;

	// One sample of the frame line; it moves on by one place per transfer.
	always_ff @(posedge clk) begin
		if (en) begin
			q <= d;
		end
	end

endmodule

// ===== rtl/obrs_mean.sv =====
module obrs_mean (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             acc,
	input  logic [obrs_pkg::SAMPLE_W-1:0]    sample,
	output obrs_pkg::frame_stat_t            stat,
	output logic [1:0][obrs_pkg::SAMPLE_W-1:0] means
);
	import obrs_pkg::*;

	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    final_sum_q;
	logic                pend_q;
	logic                pend_par_q;
	logic                load_par_q;
	logic                held_q;
	logic [POS_W-1:0]    pos_q;
	logic [1:0][SAMPLE_W-1:0] mean_q;
	logic [PROD_W-1:0]   prod;
	logic                frame_end;
	logic [SUM_W-1:0]    sum_next;

	assign frame_end = acc && (pos_q == POS_LAST);
	assign sum_next  = sum_q + SUM_W'(sample);

	// Position, running sum and frame bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			pos_q      <= '0;
			held_q     <= 1'b0;
			load_par_q <= 1'b0;
			pend_q     <= 1'b0;
			pend_par_q <= 1'b0;
		end else begin
			pend_q <= frame_end;
			if (acc) begin
				if (pos_q == POS_LAST) begin
					sum_q      <= '0;
					pos_q      <= '0;
					held_q     <= 1'b1;
					load_par_q <= ~load_par_q;
					pend_par_q <= load_par_q;
				end else begin
					sum_q <= sum_next;
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	// The final sum of a frame is registered for the reciprocal multiply.
	always_ff @(posedge clk) begin
		if (frame_end) begin
			final_sum_q <= sum_next;
		end
	end

	assign prod = PROD_W'(final_sum_q) * PROD_W'(RECIP_MULT);

	// Each frame writes its mean into its own bank, so an item of the previous
	// frame that is still in flight keeps seeing the old mean.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= '0;
		end else if (pend_q) begin
			mean_q[pend_par_q] <= prod[RECIP_SHIFT +: SAMPLE_W];
		end
	end

	assign means         = mean_q;
	assign stat.held     = held_q;
	assign stat.held_par = ~load_par_q;
	assign stat.pos      = pos_q;

endmodule

// ===== rtl/obrs_clean.sv =====
module obrs_clean (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [obrs_pkg::SAMPLE_W-1:0]      thresh,
	input  logic [1:0][obrs_pkg::SAMPLE_W-1:0] means,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  obrs_pkg::held_item_t               item,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [obrs_pkg::SAMPLE_W-1:0]      out_sample,
	output logic                               out_replaced,
	output logic                               out_last
);
	import obrs_pkg::*;

	logic                valid_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                replaced_q;
	logic                last_q;
	logic [SAMPLE_W-1:0] last_clean_q;
	logic [SAMPLE_W-1:0] mean;
	logic [SAMPLE_W-1:0] dev;
	logic                replaced;
	logic [SAMPLE_W-1:0] clean;
	logic [SAMPLE_W:0]   pair_sum;
	logic                take;

	assign in_ready = !valid_q || out_ready;
	assign take     = in_valid && in_ready;

	// Deviation from the frame mean, replacement and the two-tap average.
	always_comb begin
		mean     = means[item.par];
		dev      = (item.held >= mean) ? (item.held - mean) : (mean - item.held);
		replaced = dev > thresh;
		clean    = replaced ? last_clean_q : item.held;
		pair_sum = {1'b0, clean} + {1'b0, last_clean_q};
	end

	// Output register and the last cleaned sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			last_clean_q <= '0;
		end else begin
			if (take) begin
				valid_q      <= 1'b1;
				last_clean_q <= clean;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_q   <= pair_sum[SAMPLE_W:1];
			replaced_q <= replaced;
			last_q     <= item.last;
		end
	end

	assign out_valid    = valid_q;
	assign out_sample   = sample_q;
	assign out_replaced = replaced_q;
	assign out_last     = last_q;

endmodule

// ===== rtl/block_outlier_reject_smoother.sv =====
// Frame outlier rejection with two-tap smoothing.
// Input stream s_*: one converter word per transfer in s_tdata; bits 11..0 are
// the sample, the upper bits are ignored. Samples form frames of BLOCK_LEN.
// Output stream m_*: one result per input transfer once a whole frame has been
// stored. m_tdata carries the smoothed sample, m_tuser is set when the stored
// sample strayed from its frame mean by more than the threshold and was
// replaced by the last cleaned sample, m_tlast marks the last sample of a frame.
// The first frame produces no output.
// The stored frame runs through a line of BLOCK_LEN sample cells that shifts
// once per input transfer; its end is the sample that entered one frame ago.
// Each result passes the first-stage register and the obrs_clean output
// register. Throughput: one transfer per cycle on both sides while m_tready
// is high; the frame mean is a reciprocal multiply of the registered sum, in its own bank.
// cfg_we writes the 12-bit threshold from cfg_wdata; write it only when idle.
// Reset clears the frame count, the running sum, the means and the last cleaned
// sample, and sets the threshold to 400. When m_tready is low the result holds
// on m_*, one more item waits in the pipeline, and s_tready then drops.
module block_outlier_reject_smoother (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [obrs_pkg::WORD_W-1:0]   s_tdata,   // raw_word
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,   // smoothed_sample, zero pad
	output logic                          m_tuser,   // was_replaced
	output logic                          m_tlast,   // frame_last
	input  logic                          cfg_we,
	input  logic [obrs_pkg::SAMPLE_W-1:0] cfg_wdata
);
	import obrs_pkg::*;

	logic                     acc;
	logic [SAMPLE_W-1:0]      sample;
	logic [SAMPLE_W-1:0]      tap [BLOCK_LEN+1];
	frame_stat_t              stat;
	logic [1:0][SAMPLE_W-1:0] means;
	logic [SAMPLE_W-1:0]      thresh_q;
	logic                     valid_s1;
	held_item_t               item_s1;
	logic                     s1_ready;
	logic [SAMPLE_W-1:0]      out_sample;

	assign sample   = s_tdata[SAMPLE_W-1:0];
	assign s_tready = !valid_s1 || s1_ready;
	assign acc      = s_tvalid && s_tready;

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			thresh_q <= cfg_wdata;
		end
	end

	// Frame line: the end of the line is the stored sample at this position.
	assign tap[0] = sample;
	for (genvar i = 0; i < BLOCK_LEN; i++) begin : g_cell
		obrs_cell u_cell (
			.clk (clk),
			.en  (acc),
			.d   (tap[i]),
			.q   (tap[i+1])
		);
	end

	obrs_mean u_mean (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.sample (sample),
		.stat   (stat),
		.means  (means)
	);

	// First stage: the stored sample read out by an input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc && stat.held) begin
			valid_s1 <= 1'b1;
		end else if (s1_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1.held <= tap[BLOCK_LEN];
			item_s1.par  <= stat.held_par;
			item_s1.last <= (stat.pos == POS_LAST);
		end
	end

	obrs_clean u_clean (
		.clk          (clk),
		.arst_n       (arst_n),
		.thresh       (thresh_q),
		.means        (means),
		.in_valid     (valid_s1),
		.in_ready     (s1_ready),
		.item         (item_s1),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_sample   (out_sample),
		.out_replaced (m_tuser),
		.out_last     (m_tlast)
	);

	assign m_tdata = {{(16 - SAMPLE_W){1'b0}}, out_sample};

endmodule

// ===== tb/block_outlier_reject_smoother_tb.sv =====
module block_outlier_reject_smoother_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import obrs_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int NUM_PHASES  = 6;

	// One smoothed output sample as the block should deliver it.
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                replaced;
		logic                last;
	} smooth_result_t;

	// Shapes of generated frames.
	typedef enum int {PROF_NOISE, PROF_CLUSTER, PROF_FLAT} frame_profile_t;

	// Tracks the frame store, the mean and the last cleaned sample, and keeps the
	// smoothed samples still owed by the block in arrival order.
	class smoother_scoreboard;
		logic [SAMPLE_W-1:0] frame_mem [BLOCK_LEN];
		logic [SUM_W-1:0]    frame_sum;
		logic [SAMPLE_W-1:0] frame_mean;
		logic [POS_W-1:0]    load_pos;
		logic                have_frame;
		logic [SAMPLE_W-1:0] prev_clean;
		logic [SAMPLE_W-1:0] threshold;
		smooth_result_t      due_results [$];
		int                  errors;
		int                  checked;
		int                  replaced_count;
		int                  frames_closed;

		function new();
			frame_sum      = '0;
			frame_mean     = '0;
			load_pos       = '0;
			have_frame     = 1'b0;
			prev_clean     = '0;
			threshold      = THRESH_RESET;
			errors         = 0;
			checked        = 0;
			replaced_count = 0;
			frames_closed  = 0;
		endfunction

		function void set_threshold(logic [SAMPLE_W-1:0] value);
			threshold = value;
		endfunction

		// An accepted word emits the held sample at the current position, then
		// overwrites that position with the new sample.
		function void note_input(logic [WORD_W-1:0] word);
			logic [SAMPLE_W-1:0] held;
			logic [SAMPLE_W-1:0] dev;
			logic [SAMPLE_W-1:0] clean;
			logic                hit;
			smooth_result_t      r;
			if (have_frame) begin
				held = frame_mem[load_pos];
				dev = (held >= frame_mean) ? held - frame_mean : frame_mean - held;
				hit = dev > threshold;
				clean = hit ? prev_clean : held;
				r.sample = SAMPLE_W'(({1'b0, clean} + {1'b0, prev_clean}) >> 1);
				r.replaced = hit;
				r.last = (load_pos == POS_LAST);
				due_results.push_back(r);
				prev_clean = clean;
				if (hit) begin
					replaced_count++;
				end
			end
			frame_mem[load_pos] = word[SAMPLE_W-1:0];
			frame_sum = frame_sum + SUM_W'(word[SAMPLE_W-1:0]);
			if (load_pos == POS_LAST) begin
				frame_mean = SAMPLE_W'(frame_sum / BLOCK_LEN);
				frame_sum = '0;
				load_pos = '0;
				have_frame = 1'b1;
				frames_closed++;
			end else begin
				load_pos = load_pos + POS_W'(1);
			end
		endfunction

		// Compares one output transfer with the oldest owed sample.
		function void check_result(logic [15:0] data, logic repl, logic last);
			smooth_result_t want;
			if (due_results.size() == 0) begin
				$error("Output transfer with nothing expected: m_tdata %0d", data);
				errors++;
				return;
			end
			want = due_results.pop_front();
			checked++;
			if (data !== 16'(want.sample)) begin
				$error("smoothed_sample: expected %0d, actual %0d", want.sample, data);
				errors++;
			end
			if (repl !== want.replaced) begin
				$error("was_replaced: expected %0d, actual %0d", want.replaced, repl);
				errors++;
			end
			if (last !== want.last) begin
				$error("frame_last: expected %0d, actual %0d", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [WORD_W-1:0]   s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [15:0]         m_tdata;
	logic                m_tuser;
	logic                m_tlast;
	logic                cfg_we = 1'b0;
	logic [SAMPLE_W-1:0] cfg_wdata = '0;

	smoother_scoreboard sb = new();

	bit             send_gaps = 1'b1;
	bit             ready_gaps = 1'b1;
	int             stall_cycles = 0;
	int             gen_pos = 0;
	frame_profile_t profile = PROF_NOISE;
	int             level = 0;
	int             spread = 0;

	block_outlier_reject_smoother u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver stalls at random unless stalls are switched off.
	always @(posedge clk) begin
		m_tready <= !ready_gaps || ($urandom_range(0, 99) >= 22);
	end

	// Scores every transfer on both sides and watches for a hung pipeline.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_input(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata, m_tuser, m_tlast);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Next random word: each frame gets a profile of its own, mostly a tight
	// cluster with a few spikes, sometimes pure noise or a flat level.
	function automatic logic [WORD_W-1:0] next_random_word();
		int                  s;
		int unsigned         pick;
		logic [SAMPLE_W-1:0] smp;
		if (gen_pos == 0) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				profile = PROF_NOISE;
			end else if (pick < 25) begin
				profile = PROF_FLAT;
				case ($urandom_range(0, 2))
					0: level = 0;
					1: level = 4095;
					default: level = int'($urandom_range(0, 4095));
				endcase
			end else begin
				profile = PROF_CLUSTER;
				level = int'($urandom_range(0, 4095));
				spread = int'($urandom_range(0, 500));
			end
		end
		case (profile)
			PROF_NOISE: smp = SAMPLE_W'($urandom_range(0, 4095));
			PROF_FLAT:  smp = SAMPLE_W'(level);
			default: begin
				if ($urandom_range(0, 99) < 8) begin
					smp = SAMPLE_W'($urandom_range(0, 4095));
				end else begin
					s = level + int'($urandom_range(0, 2 * spread)) - spread;
					if (s < 0) begin
						s = 0;
					end else if (s > 4095) begin
						s = 4095;
					end
					smp = SAMPLE_W'(s);
				end
			end
		endcase
		return {4'($urandom_range(0, 15)), smp};
	endfunction

	// Offers one word and holds it until the transfer completes.
	task automatic push_word(input logic [WORD_W-1:0] word);
		while (send_gaps && $urandom_range(0, 99) < 22) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		gen_pos = (gen_pos == BLOCK_LEN - 1) ? 0 : gen_pos + 1;
	endtask

	// Stops sending and waits until every owed sample has come out, then lets
	// words still in the pipeline that owe nothing drain. The first edge lets the
	// monitor score the last input transfer before the queue is read.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.due_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [SAMPLE_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_threshold(value);
	endtask

	initial begin
		logic [WORD_W-1:0]   directed_words [16];
		logic [SAMPLE_W-1:0] thr_plan [NUM_PHASES];
		bit                  gap_plan [NUM_PHASES];

		// Extremes of the word, with and without the ignored upper bits.
		directed_words = '{16'h0000, 16'hFFFF, 16'h0FFF, 16'hF000, 16'h8000, 16'h7FFF,
			16'h0800, 16'h07FF, 16'h0001, 16'hFFFE, 16'hA5A5, 16'h5A5A, 16'h1234,
			16'hEDCB, 16'h0FFF, 16'h0000};

		// The first phase runs on the reset threshold; the rest change it while
		// a frame is partly loaded. The third phase runs without stalls on either side.
		thr_plan = '{THRESH_RESET, 12'd0, 12'd4095, 12'd0, 12'd1, THRESH_RESET};
		thr_plan[3] = SAMPLE_W'($urandom_range(0, 4095));
		gap_plan = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				settle();
				write_threshold(thr_plan[ph]);
			end
			send_gaps = gap_plan[ph];
			ready_gaps = gap_plan[ph];
			if (ph == 0) begin
				foreach (directed_words[i]) begin
					push_word(directed_words[i]);
				end
			end
			repeat ((ph == 0) ? 260 : 250) push_word(next_random_word());
		end

		settle();
		repeat (10) @(posedge clk);

		if (sb.due_results.size() != 0) begin
			$error("%0d expected samples never came out", sb.due_results.size());
			sb.errors++;
		end

		$display("Checked %0d smoothed samples over %0d closed frames, %0d replaced.",
			sb.checked, sb.frames_closed, sb.replaced_count);
		$display("Thresholds 400, 0, 4095, %0d, 1 and 400, each set with the pipe drained.",
			thr_plan[3]);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
